@@ rtl/core/fat_chain_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// fat_chain_allocator_assert
// Assertion macros used by the chain allocator.
// ----------------------------------------------------------------------------
`ifndef FAT_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FCA_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FCA_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ rtl/core/fca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants, codes and types of the chain allocator.
// ----------------------------------------------------------------------------
package fca_pkg;
  localparam int BLOCKS    = 1024;
  localparam int MAX_FILES = 16;
  localparam int BW        = $clog2(BLOCKS);
  localparam int FW        = $clog2(MAX_FILES);
  localparam int UW        = $clog2(MAX_FILES + 1);
  localparam int CW        = $clog2(BLOCKS + 1);
  localparam int LW        = 12;
  localparam logic [LW-1:0] END_MARK = '1;
  localparam logic [BW-1:0] FIRST_DATA = BW'(2);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BAD_POS  = 3'd4;
  localparam logic [2:0] ST_ZERO_LEN = 3'd5;

  // Widths used across the design.
  typedef logic [BW-1:0] blk_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [UW-1:0] used_t;
  typedef logic [LW-1:0] link_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_SCAN_WAIT, S_WALK, S_WALK_WAIT,
    S_LINK, S_FINISH, S_OUT
  } state_t;

  // Link table port request.
  typedef struct packed {
    logic          rd;
    logic [BW-1:0] raddr;
    logic          wr;
    logic [BW-1:0] waddr;
    logic [LW-1:0] wdata;
  } lt_req_t;
endpackage

@@ rtl/core/fca_link_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_link_ram
// Link table memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fca_link_ram (
  input  logic                        clk,
  input  fca_pkg::lt_req_t            req,
  output logic [fca_pkg::LW-1:0]      rdata
);
  logic [fca_pkg::LW-1:0] mem [fca_pkg::BLOCKS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr) mem[req.waddr] <= req.wdata;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.rd) rdata <= mem[req.raddr];
  end
endmodule

@@ rtl/core/fat_chain_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table chain allocator built around one link table memory.
// ----------------------------------------------------------------------------
// channel  direction  fields
// in       input      func, file_id, block_count, position
// out      output     status, result_file, start_block, file_blocks, free_blocks
// One word is handled at a time; each link table probe is a read state and a
// state acting on the registered data. A create scans from block 2 up to
// its last claimed block; an insert scans for the lowest free block and then
// walks position links. After reset a clearing pass zeroes the table; no word
// is taken meanwhile. A stalled result holds and the next word waits for it.
module fat_chain_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [3:0]                 file_id,
  input  logic [9:0]                 block_count,
  input  logic [9:0]                 position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 status,
  output logic [3:0]                 result_file,
  output logic [9:0]                 start_block,
  output logic [9:0]                 file_blocks,
  output logic [9:0]                 free_blocks
);
  `include "fat_chain_allocator_assert.svh"

  fca_pkg::state_t  state, state_next;
  fca_pkg::lt_req_t req;
  fca_pkg::link_t   rdata;

  // File table and counters.
  fca_pkg::blk_t  f_start [fca_pkg::MAX_FILES];
  fca_pkg::cnt_t  f_len   [fca_pkg::MAX_FILES];
  fca_pkg::used_t files_used;
  fca_pkg::cnt_t  free_count;

  // Working registers of the word in progress.
  fca_pkg::blk_t clr_addr, scan, prev, first, cur, blk;
  fca_pkg::cnt_t cnt, walk_i;
  logic          op_ins;
  logic [3:0]    op_fid;
  logic [9:0]    op_count, op_pos;
  logic          have_first;

  // Decoded conditions.
  logic          chk_err;
  logic [2:0]    chk_status;
  logic          scan_free, scan_last, scan_take, scan_fail, link_ok, walk_more;

  fca_link_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  // Conditions on the registered link table data.
  assign scan_free = (rdata == '0);
  assign scan_last = (scan == fca_pkg::blk_t'(fca_pkg::BLOCKS - 1));
  assign scan_take = scan_free &&
                     (op_ins || (cnt + fca_pkg::cnt_t'(1) == fca_pkg::cnt_t'(op_count)));
  assign scan_fail = scan_last && !scan_free && (op_ins || !have_first);
  assign link_ok   = (rdata < fca_pkg::link_t'(fca_pkg::BLOCKS)) &&
                     (rdata >= fca_pkg::link_t'(fca_pkg::FIRST_DATA));
  assign walk_more = (walk_i < fca_pkg::cnt_t'(op_pos)) && link_ok;

  // Request checks, in the order in which they take effect.
  always_comb begin
    chk_err    = 1'b1;
    chk_status = fca_pkg::ST_OK;
    if (!op_ins) begin
      if (op_count == '0) chk_status = fca_pkg::ST_ZERO_LEN;
      else if (files_used >= fca_pkg::used_t'(fca_pkg::MAX_FILES))
        chk_status = fca_pkg::ST_FULL;
      else if (fca_pkg::cnt_t'(op_count) > free_count)
        chk_status = fca_pkg::ST_NO_SPACE;
      else chk_err = 1'b0;
    end else begin
      if (fca_pkg::used_t'(op_fid) >= files_used) chk_status = fca_pkg::ST_UNKNOWN;
      else if (fca_pkg::cnt_t'(op_pos) > f_len[op_fid])
        chk_status = fca_pkg::ST_BAD_POS;
      else if (free_count == '0) chk_status = fca_pkg::ST_NO_SPACE;
      else chk_err = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fca_pkg::S_CLEAR: if (clr_addr == fca_pkg::blk_t'(fca_pkg::BLOCKS - 1))
                          state_next = fca_pkg::S_IDLE;
      fca_pkg::S_IDLE:  if (in_valid) state_next = fca_pkg::S_CHECK;
      fca_pkg::S_CHECK: begin
        if (chk_err) state_next = fca_pkg::S_OUT;
        else state_next = fca_pkg::S_SCAN;
      end
      fca_pkg::S_SCAN:  state_next = fca_pkg::S_SCAN_WAIT;
      fca_pkg::S_SCAN_WAIT: begin
        if (scan_take) begin
          if (op_ins) state_next = fca_pkg::S_WALK;
          else state_next = fca_pkg::S_FINISH;
        end else if (scan_fail) state_next = fca_pkg::S_OUT;
        else if (scan_last) state_next = fca_pkg::S_FINISH;
        else state_next = fca_pkg::S_SCAN;
      end
      fca_pkg::S_WALK:  state_next = fca_pkg::S_WALK_WAIT;
      fca_pkg::S_WALK_WAIT: begin
        if (walk_more) state_next = fca_pkg::S_WALK;
        else state_next = fca_pkg::S_LINK;
      end
      fca_pkg::S_LINK:  state_next = fca_pkg::S_FINISH;
      fca_pkg::S_FINISH: state_next = fca_pkg::S_OUT;
      fca_pkg::S_OUT:   if (out_ready) state_next = fca_pkg::S_IDLE;
      default:          state_next = fca_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs and memory port requests.
  always_comb begin
    in_ready  = (state == fca_pkg::S_IDLE);
    out_valid = (state == fca_pkg::S_OUT);
    req = '0;
    case (state)
      fca_pkg::S_CLEAR: begin
        req.wr = 1'b1; req.waddr = clr_addr;
      end
      fca_pkg::S_SCAN: begin
        req.rd = 1'b1; req.raddr = scan;
      end
      fca_pkg::S_SCAN_WAIT: begin
        // A newly claimed create block is linked from the previous one.
        if (!op_ins && scan_free && have_first) begin
          req.wr = 1'b1; req.waddr = prev; req.wdata = fca_pkg::link_t'(scan);
        end
      end
      fca_pkg::S_WALK: begin
        req.rd = 1'b1; req.raddr = cur;
      end
      fca_pkg::S_LINK: begin
        req.wr = 1'b1; req.waddr = blk; req.wdata = rdata;
      end
      fca_pkg::S_FINISH: begin
        req.wr = 1'b1;
        if (op_ins) begin
          req.waddr = cur; req.wdata = fca_pkg::link_t'(blk);
        end else begin
          req.waddr = prev; req.wdata = fca_pkg::END_MARK;
        end
      end
      default: ;
    endcase
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fca_pkg::S_CLEAR;
      clr_addr   <= '0;
      files_used <= '0;
      free_count <= fca_pkg::cnt_t'(fca_pkg::BLOCKS - 2);
    end else begin
      state <= state_next;
      case (state)
        fca_pkg::S_CLEAR: clr_addr <= clr_addr + fca_pkg::blk_t'(1);
        fca_pkg::S_IDLE: if (in_valid) begin
          op_ins <= func; op_fid <= file_id;
          op_count <= block_count; op_pos <= position;
        end
        fca_pkg::S_CHECK: begin
          scan <= fca_pkg::FIRST_DATA; have_first <= 1'b0; cnt <= '0;
          status <= chk_status;
          result_file <= '0; start_block <= '0; file_blocks <= '0;
          free_blocks <= free_count[9:0];
        end
        fca_pkg::S_SCAN_WAIT: begin
          if (scan_free) begin
            if (op_ins) begin
              blk <= scan; cur <= f_start[op_fid]; walk_i <= fca_pkg::cnt_t'(1);
            end else begin
              if (!have_first) first <= scan;
              have_first <= 1'b1;
              prev <= scan;
              cnt <= cnt + fca_pkg::cnt_t'(1);
            end
          end
          if (scan_fail) status <= fca_pkg::ST_NO_SPACE;
          scan <= scan + fca_pkg::blk_t'(1);
        end
        fca_pkg::S_WALK_WAIT: if (walk_more) begin
          cur <= fca_pkg::blk_t'(rdata);
          walk_i <= walk_i + fca_pkg::cnt_t'(1);
        end
        fca_pkg::S_FINISH: begin
          if (op_ins) begin
            f_len[op_fid] <= f_len[op_fid] + fca_pkg::cnt_t'(1);
            free_count <= free_count - fca_pkg::cnt_t'(1);
            free_blocks <= 10'(free_count - fca_pkg::cnt_t'(1));
            result_file <= op_fid; start_block <= f_start[op_fid];
            file_blocks <= 10'(f_len[op_fid] + fca_pkg::cnt_t'(1));
          end else begin
            f_start[files_used[fca_pkg::FW-1:0]] <= first;
            f_len[files_used[fca_pkg::FW-1:0]] <= cnt;
            free_count <= free_count - cnt;
            free_blocks <= 10'(free_count - cnt);
            files_used <= files_used + fca_pkg::used_t'(1);
            result_file <= files_used[fca_pkg::FW-1:0];
            start_block <= first; file_blocks <= cnt[9:0];
          end
        end
        default: ;
      endcase
    end
  end

  `FCA_ASSERT_IMP(a_one_side, clk, rst, 1'b1, !(in_ready && out_valid))
  `FCA_ASSERT_NXT(a_take, clk, rst, in_valid && in_ready,
                  state == fca_pkg::S_CHECK)
  `FCA_ASSERT_IMP(a_free_range, clk, rst, 1'b1,
                  free_count <= fca_pkg::cnt_t'(fca_pkg::BLOCKS - 2))
  `FCA_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                  out_valid && $stable(status) && $stable(free_blocks))
  `FCA_ASSERT_IMP(a_files_range, clk, rst, 1'b1,
                  files_used <= fca_pkg::used_t'(fca_pkg::MAX_FILES))
endmodule

@@ verif/tb_fat_chain_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_chain_allocator
// Self-checking bench for the chain allocator: a queue-fed driver, a table
// model that predicts every response word, and a monitor comparing fields.
// ----------------------------------------------------------------------------
module tb_fat_chain_allocator;
  localparam int LIMIT_CYCLES = 15_000_000;
  localparam logic FN_CREATE  = 1'b0;
  localparam logic FN_INSERT  = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] file_id;
    logic [9:0] block_count;
    logic [9:0] position;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] result_file;
    logic [9:0] start_block;
    logic [9:0] file_blocks;
    logic [9:0] free_blocks;
  } response_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = 1'b0;
  logic [3:0] file_id = '0;
  logic [9:0] block_count = '0;
  logic [9:0] position = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] status;
  logic [3:0] result_file;
  logic [9:0] start_block;
  logic [9:0] file_blocks;
  logic [9:0] free_blocks;

  request_t  pending_words[$];
  response_t expected_words[$];
  int        errors = 0;
  int        cycles = 0;
  int        sent = 0;
  int        received = 0;

  // Table model used to predict responses.
  fca_pkg::link_t links[fca_pkg::BLOCKS];
  logic [9:0]     start_of[fca_pkg::MAX_FILES];
  logic [9:0]     length_of[fca_pkg::MAX_FILES];
  int             files_made = 0;
  int             free_left = fca_pkg::BLOCKS - 2;

  // Light shadow used by the generator to choose legal requests.
  int gen_len[fca_pkg::MAX_FILES];
  int gen_files = 0;
  int gen_free = fca_pkg::BLOCKS - 2;

  fat_chain_allocator DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int lowest_free();
    for (int b = 2; b < fca_pkg::BLOCKS; b++)
      if (links[b] == '0) return b;
    return fca_pkg::BLOCKS;
  endfunction

  // Apply one request to the table model and queue the response it gives.
  task automatic predict_allocation(input request_t rq);
    response_t rs;
    int first, prev, blk, n, cur, nxt;
    rs = '0;
    if (rq.func == FN_CREATE) begin
      if (rq.block_count == 0) rs.status = fca_pkg::ST_ZERO_LEN;
      else if (files_made >= fca_pkg::MAX_FILES) rs.status = fca_pkg::ST_FULL;
      else if (rq.block_count > free_left) rs.status = fca_pkg::ST_NO_SPACE;
      else begin
        first = lowest_free();
        links[first] = fca_pkg::END_MARK;
        prev = first;
        for (n = 1; n < rq.block_count; n++) begin
          blk = lowest_free();
          if (blk >= fca_pkg::BLOCKS) break;
          links[prev] = fca_pkg::link_t'(blk);
          links[blk] = fca_pkg::END_MARK;
          prev = blk;
        end
        start_of[files_made] = 10'(first);
        length_of[files_made] = 10'(n);
        free_left -= n;
        files_made++;
        rs.status = fca_pkg::ST_OK;
        rs.result_file = 4'(files_made - 1);
        rs.start_block = 10'(first);
        rs.file_blocks = 10'(n);
      end
    end else begin
      blk = lowest_free();
      if (rq.file_id >= files_made) rs.status = fca_pkg::ST_UNKNOWN;
      else if (rq.position > length_of[rq.file_id]) rs.status = fca_pkg::ST_BAD_POS;
      else if (free_left == 0 || blk >= fca_pkg::BLOCKS) rs.status = fca_pkg::ST_NO_SPACE;
      else begin
        cur = start_of[rq.file_id];
        for (int i = 1; i < rq.position; i++) begin
          nxt = links[cur];
          if (nxt >= fca_pkg::BLOCKS || nxt < 2) break;
          cur = nxt;
        end
        links[blk] = links[cur];
        links[cur] = fca_pkg::link_t'(blk);
        length_of[rq.file_id]++;
        free_left--;
        rs.status = fca_pkg::ST_OK;
        rs.result_file = rq.file_id;
        rs.start_block = start_of[rq.file_id];
        rs.file_blocks = length_of[rq.file_id];
      end
    end
    rs.free_blocks = 10'(free_left);
    expected_words.push_back(rs);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH response %0d %s: got %0d expected %0d", received, what, got, want);
  endtask

  // Queue one request, keeping the generator's shadow in step.
  task automatic queue_request(input logic fn, input int fid, input int cnt, input int pos);
    request_t rq;
    rq.func = fn;
    rq.file_id = 4'(fid);
    rq.block_count = 10'(cnt);
    rq.position = 10'(pos);
    pending_words.push_back(rq);
    if (fn == FN_CREATE) begin
      if (cnt != 0 && gen_files < fca_pkg::MAX_FILES && cnt <= gen_free) begin
        gen_len[gen_files] = cnt;
        gen_files++;
        gen_free -= cnt;
      end
    end else if (fid < gen_files && pos <= gen_len[fid] && gen_free > 0) begin
      gen_len[fid]++;
      gen_free--;
    end
  endtask

  // Driver: presents queued words and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_allocation({func, file_id, block_count, position});
        sent++;
      end
      if (pending_words.size() > 0 &&
          ((sent > 200 && sent < 300) || $urandom_range(0, 99) >= 17)) begin
        {func, file_id, block_count, position} <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each response word with the oldest prediction.
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected", 1, 0);
        end else begin
          want = expected_words.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (result_file !== want.result_file)
            report_mismatch("result_file", result_file, want.result_file);
          if (start_block !== want.start_block)
            report_mismatch("start_block", start_block, want.start_block);
          if (file_blocks !== want.file_blocks)
            report_mismatch("file_blocks", file_blocks, want.file_blocks);
          if (free_blocks !== want.free_blocks)
            report_mismatch("free_blocks", free_blocks, want.free_blocks);
        end
        received++;
      end
      out_ready <= (received > 150 && received < 260) || $urandom_range(0, 99) >= 17;
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int pick, fid;
    foreach (links[i]) links[i] = '0;
    foreach (start_of[i]) start_of[i] = '0;
    foreach (length_of[i]) length_of[i] = '0;
    foreach (gen_len[i]) gen_len[i] = 0;

    // Directed: zero length, unknown file, long file, edge positions, no space.
    queue_request(FN_CREATE, 9, 0, 1022);
    queue_request(FN_INSERT, 0, 0, 0);
    queue_request(FN_CREATE, 15, 1, 0);
    queue_request(FN_CREATE, 0, 600, 0);
    queue_request(FN_CREATE, 0, 3, 0);
    queue_request(FN_INSERT, 0, 0, 0);
    queue_request(FN_INSERT, 0, 0, 1);
    queue_request(FN_INSERT, 0, 0, 2);
    queue_request(FN_INSERT, 0, 0, 5);
    queue_request(FN_INSERT, 1, 0, 600);
    queue_request(FN_INSERT, 1, 1022, 1022);
    queue_request(FN_INSERT, 1, 0, 1);
    queue_request(FN_INSERT, 2, 0, 0);
    queue_request(FN_INSERT, 2, 0, 4);
    queue_request(FN_INSERT, 2, 0, 9);
    queue_request(FN_INSERT, 3, 0, 0);
    queue_request(FN_INSERT, 15, 1022, 1022);
    queue_request(FN_CREATE, 0, 1022, 0);
    queue_request(FN_CREATE, 0, 1, 1022);

    // Let the directed words drain fully before the random part.
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);

    // Random: mostly legal inserts, some creates, the rest unrestricted noise.
    for (int k = 0; k < 560; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 68 && gen_files > 0) begin
        fid = $urandom_range(0, gen_files - 1);
        queue_request(FN_INSERT, fid, $urandom_range(0, 1022),
                      $urandom_range(0, gen_len[fid]));
      end else if (pick < 85) begin
        queue_request(FN_CREATE, $urandom_range(0, 15),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1022)
                                                  : $urandom_range(1, 8),
                      $urandom_range(0, 1022));
      end else begin
        queue_request(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                      $urandom_range(0, 1022), $urandom_range(0, 1022));
      end
    end

    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Reset is held at the start, then released.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end
endmodule

@@ fat_chain_allocator.f @@
+incdir+rtl/core
rtl/core/fca_pkg.sv
rtl/core/fca_link_ram.sv
rtl/core/fat_chain_allocator.sv
verif/tb_fat_chain_allocator.sv
